[hdl/catmull_rom_route_sampler_macros.svh]
// ---------------------------------------------------------------------------
// Route sampler assertion macros
// Clocked property macros for the route sampler checker.
// ---------------------------------------------------------------------------
`ifndef CATMULL_ROM_ROUTE_SAMPLER_MACROS_SVH
`define CATMULL_ROM_ROUTE_SAMPLER_MACROS_SVH

// same-cycle implication, disabled in reset
`define CRRS_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("route sampler check failed");

// next-cycle implication, disabled in reset
`define CRRS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("route sampler check failed");

`endif

[hdl/crrs_pkg.sv]
// ---------------------------------------------------------------------------
// Route sampler package
// Shared widths, controller commands, status, coefficient helpers and arctangent table.
// ---------------------------------------------------------------------------
package crrs_pkg;

    localparam int MAX_SAMPLES_DEF = 32;
    localparam int CFG_W    = 6;
    localparam int PT_W     = 32;
    localparam int COEF_W   = 36;
    localparam int QW       = 34;
    localparam int CW       = 62;
    localparam int ZW       = 20;
    localparam int HW       = 16;
    localparam int SUM_W    = 20;
    localparam int NORM_HI  = 58;
    localparam int NORM_LO  = 50;
    localparam int RECIP_SH = 22;
    localparam int DIV_STEPS  = QW;
    localparam int MAC_STEPS  = 5;
    localparam int CORD_STEPS = 16;

    localparam logic signed [ZW-1:0]   PI_Q16   = 20'sd205887;
    localparam logic signed [ZW-1:0]   HEAD_MAX = 20'sd25736;
    localparam logic [19:0]            RECIP10  = 20'd419431;
    localparam logic [3:0]             HCNT_TOP = 4'd9;
    localparam logic signed [PT_W-1:0] SAT_MAX  = 32'sh7FFF_FFFF;
    localparam logic signed [PT_W-1:0] SAT_MIN  = 32'sh8000_0000;

    typedef enum logic [3:0] {
        OP_NONE, OP_LOAD, OP_SEG, OP_WGT, OP_MAC, OP_DINIT, OP_DSTEP, OP_DFIN,
        OP_NINIT, OP_NSTEP, OP_CSTEP, OP_HACC, OP_HDIV, OP_EMIT, OP_FINISH
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [5:0] step;
        logic       second;
        logic       last;
    } t_cmd;

    typedef struct packed {
        logic ps_lt2;
        logic fin;
        logic last_i;
        logic norm_done;
        logic out_free;
    } t_stat;

    typedef logic signed [COEF_W-1:0] t_co;
    typedef logic signed [PT_W-1:0]   t_pt;

    typedef struct packed {
        t_co a;
        t_co b;
        t_co c;
        t_co d;
    } t_coef;

    function automatic t_coef coef_first(t_pt p0, t_pt p1, t_pt p2);
        t_coef r;
        t_co   e0, e1, e2;
        e0 = t_co'(p0);
        e1 = t_co'(p1);
        e2 = t_co'(p2);
        r.a = '0;
        r.b = e0 - (e1 <<< 1) + e2;
        r.c = -(e0 <<< 1) - e0 + (e1 <<< 2) - e2;
        r.d = e0 <<< 1;
        return r;
    endfunction

    function automatic t_coef coef_last(t_pt p0, t_pt p1, t_pt p2);
        t_coef r;
        t_co   e0, e1, e2;
        e0 = t_co'(p0);
        e1 = t_co'(p1);
        e2 = t_co'(p2);
        r.a = '0;
        r.b = e0 - (e1 <<< 1) + e2;
        r.c = e2 - e0;
        r.d = e1 <<< 1;
        return r;
    endfunction

    function automatic t_coef coef_inner(t_pt p0, t_pt p1, t_pt p2, t_pt p3);
        t_coef r;
        t_co   e0, e1, e2, e3;
        e0 = t_co'(p0);
        e1 = t_co'(p1);
        e2 = t_co'(p2);
        e3 = t_co'(p3);
        r.a = -e0 + (e1 <<< 1) + e1 - (e2 <<< 1) - e2 + e3;
        r.b = (e0 <<< 1) - (e1 <<< 2) - e1 + (e2 <<< 2) - e3;
        r.c = e2 - e0;
        r.d = e1 <<< 1;
        return r;
    endfunction

    function automatic logic signed [ZW-1:0] atan_lut(logic [3:0] k);
        logic signed [ZW-1:0] v;
        case (k)
            4'd0:    v = 20'sd51472;
            4'd1:    v = 20'sd30386;
            4'd2:    v = 20'sd16055;
            4'd3:    v = 20'sd8150;
            4'd4:    v = 20'sd4091;
            4'd5:    v = 20'sd2047;
            4'd6:    v = 20'sd1024;
            4'd7:    v = 20'sd512;
            4'd8:    v = 20'sd256;
            4'd9:    v = 20'sd128;
            4'd10:   v = 20'sd64;
            4'd11:   v = 20'sd32;
            4'd12:   v = 20'sd16;
            4'd13:   v = 20'sd8;
            4'd14:   v = 20'sd4;
            default: v = 20'sd2;
        endcase
        return v;
    endfunction

endpackage

[hdl/crrs_ctrl.sv]
// ---------------------------------------------------------------------------
// Route sampler controller
// Sequences load, segment setup, per-sample evaluation, heading and emit.
// ---------------------------------------------------------------------------
module crrs_ctrl
    import crrs_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE, S_SEG, S_WGT0, S_WGT1, S_MAC, S_DINIT, S_DIV, S_DFIN,
        S_NINIT, S_NORM, S_CORD, S_HACC, S_HDIV, S_EMIT, S_FIN
    } t_state;

    t_state     r_state, n_state;
    logic [5:0] r_cnt, n_cnt;
    logic       r_second, n_second;
    logic       w_last;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_last     = i_stat.last_i && (r_second || !i_stat.fin);

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_second    = r_second;
        o_cmd       = '0;
        o_cmd.op    = OP_NONE;
        o_cmd.step  = r_cnt;
        o_cmd.second = r_second;
        o_cmd.last  = w_last;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = OP_LOAD;
                    n_second = 1'b0;
                    n_state  = i_stat.ps_lt2 ? S_IDLE : S_SEG;
                end
            end
            S_SEG: begin
                o_cmd.op = OP_SEG;
                n_state  = S_WGT0;
            end
            S_WGT0: begin
                o_cmd.op   = OP_WGT;
                o_cmd.step = 6'd0;
                n_state    = S_WGT1;
            end
            S_WGT1: begin
                o_cmd.op   = OP_WGT;
                o_cmd.step = 6'd1;
                n_cnt      = '0;
                n_state    = S_MAC;
            end
            S_MAC: begin
                o_cmd.op = OP_MAC;
                if (r_cnt == 6'(MAC_STEPS - 1)) begin
                    n_state = S_DINIT;
                end else begin
                    n_cnt = r_cnt + 6'd1;
                end
            end
            S_DINIT: begin
                o_cmd.op = OP_DINIT;
                n_cnt    = '0;
                n_state  = S_DIV;
            end
            S_DIV: begin
                o_cmd.op = OP_DSTEP;
                if (r_cnt == 6'(DIV_STEPS - 1)) begin
                    n_state = S_DFIN;
                end else begin
                    n_cnt = r_cnt + 6'd1;
                end
            end
            S_DFIN: begin
                o_cmd.op = OP_DFIN;
                n_state  = S_NINIT;
            end
            S_NINIT: begin
                o_cmd.op = OP_NINIT;
                n_state  = S_NORM;
            end
            S_NORM: begin
                if (i_stat.norm_done) begin
                    n_cnt   = '0;
                    n_state = S_CORD;
                end else begin
                    o_cmd.op = OP_NSTEP;
                end
            end
            S_CORD: begin
                o_cmd.op = OP_CSTEP;
                if (r_cnt == 6'(CORD_STEPS - 1)) begin
                    n_state = S_HACC;
                end else begin
                    n_cnt = r_cnt + 6'd1;
                end
            end
            S_HACC: begin
                o_cmd.op = OP_HACC;
                n_state  = S_HDIV;
            end
            S_HDIV: begin
                o_cmd.op = OP_HDIV;
                n_state  = S_EMIT;
            end
            S_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.op = OP_EMIT;
                    if (!i_stat.last_i) begin
                        n_state = S_WGT0;
                    end else if (i_stat.fin && !r_second) begin
                        n_second = 1'b1;
                        n_state  = S_SEG;
                    end else begin
                        n_state = S_FIN;
                    end
                end
            end
            S_FIN: begin
                o_cmd.op = OP_FINISH;
                n_state  = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_second <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_second <= n_second;
        end
    end

endmodule

[hdl/crrs_dp.sv]
// ---------------------------------------------------------------------------
// Route sampler datapath
// Point window, coefficient MAC, serial divider, CORDIC and heading mean.
// ---------------------------------------------------------------------------
module crrs_dp
    import crrs_pkg::*;
#(
    parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_cmd                   i_cmd,
    output t_stat                  o_stat,
    input  logic                   i_cfg_we,
    input  logic [CFG_W-1:0]       i_cfg_wdata,
    input  logic signed [PT_W-1:0] i_pt_x,
    input  logic signed [PT_W-1:0] i_pt_y,
    input  logic signed [PT_W-1:0] i_pt_z,
    input  logic                   i_pt_fin,
    output logic signed [PT_W-1:0] o_smp_x,
    output logic signed [PT_W-1:0] o_smp_y,
    output logic signed [PT_W-1:0] o_smp_z,
    output logic signed [HW-1:0]   o_heading,
    output logic                   o_last,
    output logic                   o_valid,
    input  logic                   i_ready
);

    localparam int SW    = $clog2(MAX_SAMPLES + 1);
    localparam int WW    = 3 * SW;
    localparam int DW    = WW + 1;
    localparam int PW    = COEF_W + WW + 1;
    localparam int ACC_W = COEF_W + WW + 3;

    logic [SW-1:0]         r_spp;
    t_pt                   r_win [3][3];
    t_pt                   r_pt  [3];
    logic [1:0]            r_ps;
    logic                  r_fin;
    t_coef                 r_coef [3];
    logic [SW-1:0]         r_i;
    logic [2*SW-1:0]       r_ii, r_is, r_ss;
    logic [WW-1:0]         r_w [4];
    logic signed [PW-1:0]  r_prod [3];
    logic signed [ACC_W-1:0] r_acc [3];
    logic                  r_neg [3];
    logic                  r_ovf [3];
    logic [DW-1:0]         r_rem [3];
    logic [QW-1:0]         r_q   [3];
    t_pt                   r_smp [3];
    t_pt                   r_prvx, r_prvy;
    logic signed [CW-1:0]  r_cx, r_cy;
    logic signed [ZW-1:0]  r_cz;
    logic                  r_zero;
    logic signed [SUM_W-1:0] r_hsum;
    logic [3:0]            r_hcnt;
    logic signed [HW-1:0]  r_hold;
    t_pt                   r_ox, r_oy, r_oz;
    logic signed [HW-1:0]  r_oh;
    logic                  r_olast, r_ovalid;

    logic [DW-1:0]         w_d;
    logic [SW-1:0]         w_cfg;
    t_coef                 w_coef [3];
    logic signed [PW-1:0]  w_prod [3];
    logic [ACC_W-1:0]      w_m [3];
    logic                  w_ovf [3];
    logic [DW-1:0]         w_rem_n [3];
    logic [QW-1:0]         w_q_n [3];
    t_pt                   w_sat [3];
    logic signed [32:0]    w_dx, w_dy;
    logic signed [CW-1:0]  w_ay, w_mx;
    logic signed [CW-1:0]  w_xs, w_ys;
    logic signed [ZW-1:0]  w_hr;
    logic signed [HW-1:0]  w_ang;
    logic [SUM_W-1:0]      w_mag;
    logic [39:0]           w_p10;
    logic [HW-1:0]         w_q10;
    logic signed [HW-1:0]  w_mean;

    assign w_d = {r_w[3], 1'b0};

    always_comb begin
        if (i_cfg_wdata == '0) begin
            w_cfg = SW'(1);
        end else if (i_cfg_wdata > CFG_W'(MAX_SAMPLES)) begin
            w_cfg = SW'(MAX_SAMPLES);
        end else begin
            w_cfg = i_cfg_wdata[SW-1:0];
        end
    end

    always_comb begin
        t_co           sel;
        logic [WW-1:0] wt;
        logic [DW:0]   r2, df;
        logic          ge;
        for (int l = 0; l < 3; l++) begin
            if (i_cmd.second) begin
                w_coef[l] = (r_ps == 2'd2) ? coef_last(r_win[l][0], r_win[l][1], r_pt[l])
                                           : coef_last(r_win[l][1], r_win[l][2], r_pt[l]);
            end else begin
                w_coef[l] = (r_ps == 2'd2)
                    ? coef_first(r_win[l][0], r_win[l][1], r_pt[l])
                    : coef_inner(r_win[l][0], r_win[l][1], r_win[l][2], r_pt[l]);
            end
            case (i_cmd.step[1:0])
                2'd0:    sel = r_coef[l].a;
                2'd1:    sel = r_coef[l].b;
                2'd2:    sel = r_coef[l].c;
                default: sel = r_coef[l].d;
            endcase
            wt = r_w[i_cmd.step[1:0]];
            w_prod[l] = PW'(sel) * PW'(signed'({1'b0, wt}));

            if (r_acc[l][ACC_W-1]) begin
                w_m[l] = ACC_W'(-r_acc[l]) + ACC_W'(w_d) - ACC_W'(1);
            end else begin
                w_m[l] = ACC_W'(r_acc[l]);
            end
            w_ovf[l] = (w_m[l][ACC_W-1:QW] >= (ACC_W - QW)'(w_d));

            r2 = {r_rem[l], r_q[l][QW-1]};
            df = r2 - {1'b0, w_d};
            ge = (r2 >= {1'b0, w_d});
            w_rem_n[l] = ge ? df[DW-1:0] : r2[DW-1:0];
            w_q_n[l]   = {r_q[l][QW-2:0], ge};

            if (r_neg[l]) begin
                w_sat[l] = (r_ovf[l] || r_q[l] > QW'(33'h1_0000_0000 >> 1)) ? SAT_MIN
                                                                            : -r_q[l][31:0];
            end else begin
                w_sat[l] = (r_ovf[l] || r_q[l] > QW'(SAT_MAX)) ? SAT_MAX : r_q[l][31:0];
            end
        end
    end

    always_comb begin
        w_dx = {r_smp[0][PT_W-1], r_smp[0]} - {r_prvx[PT_W-1], r_prvx};
        w_dy = {r_smp[1][PT_W-1], r_smp[1]} - {r_prvy[PT_W-1], r_prvy};
        w_ay = r_cy[CW-1] ? -r_cy : r_cy;
        w_mx = (r_cx > w_ay) ? r_cx : w_ay;
        w_xs = r_cx >>> i_cmd.step[3:0];
        w_ys = r_cy >>> i_cmd.step[3:0];
        w_hr = (r_cz + 20'sd4) >>> 3;
        if (r_zero) begin
            w_ang = '0;
        end else if (w_hr > HEAD_MAX) begin
            w_ang = HEAD_MAX[HW-1:0];
        end else if (w_hr < -HEAD_MAX) begin
            w_ang = HW'(-HEAD_MAX);
        end else begin
            w_ang = w_hr[HW-1:0];
        end
        w_mag  = (r_hsum < 0) ? SUM_W'(-r_hsum) : SUM_W'(r_hsum);
        w_p10  = 40'(w_mag + SUM_W'(5)) * 40'(RECIP10);
        w_q10  = w_p10[RECIP_SH+HW-1:RECIP_SH];
        w_mean = (r_hsum < 0) ? -signed'(w_q10) : signed'(w_q10);
    end

    assign o_stat.ps_lt2    = (r_ps < 2'd2);
    assign o_stat.fin       = r_fin;
    assign o_stat.last_i    = ((r_i + SW'(1)) == r_spp);
    assign o_stat.norm_done = r_zero || (w_mx >= (CW'(1) <<< NORM_HI));
    assign o_stat.out_free  = !r_ovalid || i_ready;

    assign o_smp_x   = r_ox;
    assign o_smp_y   = r_oy;
    assign o_smp_z   = r_oz;
    assign o_heading = r_oh;
    assign o_last    = r_olast;
    assign o_valid   = r_ovalid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spp <= SW'(MAX_SAMPLES);
        end else if (i_cfg_we) begin
            r_spp <= w_cfg;
        end
    end

    // route state: window, fill count, previous sample and heading mean
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int l = 0; l < 3; l++) begin
                for (int k = 0; k < 3; k++) begin
                    r_win[l][k] <= '0;
                end
            end
            r_ps   <= '0;
            r_prvx <= '0;
            r_prvy <= '0;
            r_hsum <= '0;
            r_hcnt <= '0;
            r_hold <= '0;
        end else begin
            case (i_cmd.op)
                OP_LOAD: begin
                    if (r_ps < 2'd2) begin
                        if (i_pt_fin) begin
                            for (int l = 0; l < 3; l++) begin
                                for (int k = 0; k < 3; k++) begin
                                    r_win[l][k] <= '0;
                                end
                            end
                            r_ps <= '0;
                        end else begin
                            r_win[0][r_ps] <= i_pt_x;
                            r_win[1][r_ps] <= i_pt_y;
                            r_win[2][r_ps] <= i_pt_z;
                            r_ps <= r_ps + 2'd1;
                        end
                    end
                end
                OP_HACC: begin
                    r_hsum <= r_hsum + SUM_W'(w_ang);
                end
                OP_HDIV: begin
                    if (r_hcnt == HCNT_TOP) begin
                        r_hold <= w_mean;
                        r_hsum <= '0;
                        r_hcnt <= '0;
                    end else begin
                        r_hcnt <= r_hcnt + 4'd1;
                    end
                end
                OP_EMIT: begin
                    r_prvx <= r_smp[0];
                    r_prvy <= r_smp[1];
                end
                OP_FINISH: begin
                    if (r_fin) begin
                        for (int l = 0; l < 3; l++) begin
                            for (int k = 0; k < 3; k++) begin
                                r_win[l][k] <= '0;
                            end
                        end
                        r_ps   <= '0;
                        r_prvx <= '0;
                        r_prvy <= '0;
                        r_hsum <= '0;
                        r_hcnt <= '0;
                        r_hold <= '0;
                    end else if (r_ps == 2'd2) begin
                        for (int l = 0; l < 3; l++) begin
                            r_win[l][2] <= r_pt[l];
                        end
                        r_ps <= 2'd3;
                    end else begin
                        for (int l = 0; l < 3; l++) begin
                            r_win[l][0] <= r_win[l][1];
                            r_win[l][1] <= r_win[l][2];
                            r_win[l][2] <= r_pt[l];
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // arithmetic working registers
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_LOAD: begin
                r_pt[0] <= i_pt_x;
                r_pt[1] <= i_pt_y;
                r_pt[2] <= i_pt_z;
                r_fin   <= i_pt_fin;
            end
            OP_SEG: begin
                r_i <= '0;
                for (int l = 0; l < 3; l++) begin
                    r_coef[l] <= w_coef[l];
                end
            end
            OP_WGT: begin
                if (i_cmd.step[0] == 1'b0) begin
                    r_ii <= (2*SW)'(r_i) * (2*SW)'(r_i);
                    r_is <= (2*SW)'(r_i) * (2*SW)'(r_spp);
                    r_ss <= (2*SW)'(r_spp) * (2*SW)'(r_spp);
                end else begin
                    r_w[0] <= WW'(r_ii) * WW'(r_i);
                    r_w[1] <= WW'(r_ii) * WW'(r_spp);
                    r_w[2] <= WW'(r_is) * WW'(r_spp);
                    r_w[3] <= WW'(r_ss) * WW'(r_spp);
                end
            end
            OP_MAC: begin
                for (int l = 0; l < 3; l++) begin
                    r_prod[l] <= w_prod[l];
                    if (i_cmd.step == 6'd0) begin
                        r_acc[l] <= ACC_W'(signed'({1'b0, r_w[3]}));
                    end else begin
                        r_acc[l] <= r_acc[l] + ACC_W'(r_prod[l]);
                    end
                end
            end
            OP_DINIT: begin
                for (int l = 0; l < 3; l++) begin
                    r_neg[l] <= r_acc[l][ACC_W-1];
                    r_ovf[l] <= w_ovf[l];
                    r_rem[l] <= w_m[l][QW+DW-1:QW];
                    r_q[l]   <= w_m[l][QW-1:0];
                end
            end
            OP_DSTEP: begin
                for (int l = 0; l < 3; l++) begin
                    r_rem[l] <= w_rem_n[l];
                    r_q[l]   <= w_q_n[l];
                end
            end
            OP_DFIN: begin
                for (int l = 0; l < 3; l++) begin
                    r_smp[l] <= w_sat[l];
                end
            end
            OP_NINIT: begin
                r_zero <= (w_dx == '0) && (w_dy == '0);
                if (w_dx < 0) begin
                    r_cz <= (w_dy >= 0) ? PI_Q16 : -PI_Q16;
                    r_cx <= -CW'(w_dx);
                    r_cy <= -CW'(w_dy);
                end else begin
                    r_cz <= '0;
                    r_cx <= CW'(w_dx);
                    r_cy <= CW'(w_dy);
                end
            end
            OP_NSTEP: begin
                if (w_mx < (CW'(1) <<< NORM_LO)) begin
                    r_cx <= r_cx <<< 8;
                    r_cy <= r_cy <<< 8;
                end else begin
                    r_cx <= r_cx <<< 1;
                    r_cy <= r_cy <<< 1;
                end
            end
            OP_CSTEP: begin
                if (r_cy > 0) begin
                    r_cx <= r_cx + w_ys;
                    r_cy <= r_cy - w_xs;
                    r_cz <= r_cz + atan_lut(i_cmd.step[3:0]);
                end else begin
                    r_cx <= r_cx - w_ys;
                    r_cy <= r_cy + w_xs;
                    r_cz <= r_cz - atan_lut(i_cmd.step[3:0]);
                end
            end
            OP_EMIT: begin
                r_i     <= r_i + SW'(1);
                r_ox    <= r_smp[0];
                r_oy    <= r_smp[1];
                r_oz    <= r_smp[2];
                r_oh    <= r_hold;
                r_olast <= i_cmd.last;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.op == OP_EMIT) begin
            r_ovalid <= 1'b1;
        end else if (i_ready) begin
            r_ovalid <= 1'b0;
        end
    end

endmodule

[hdl/catmull_rom_route_sampler.sv]
// ---------------------------------------------------------------------------
// Catmull-Rom route sampler
// Samples a route of Q16.16 control points along spline segments, with a
// held ten-sample mean heading on every sample.
// ---------------------------------------------------------------------------
// Usage:
//   Slave beat: one control point, tlast marks the final point of a route.
//   Master beats: S samples per segment, S from the configuration register
//   (0 reads as 1, above MAX_SAMPLES reads as MAX_SAMPLES); tlast on the
//   final sample caused by a point. The first two points give no samples;
//   the third and later give one segment, a final point one more.
//   Throughput: one point at a time. Each sample runs weight setup, the
//   MAC, the serial divider (one quotient bit a cycle over 34 bits),
//   normalisation, CORDIC and the heading/emit steps, in that order. A
//   point runs its segments in turn, S samples each; points that emit
//   nothing return straight to idle.
//   The result stands in an output register; a stalled receiver holds the
//   next finished sample until the register frees. A point can be taken
//   while its last sample still waits.
//   Reset clears the route and sets S to MAX_SAMPLES.
// ---------------------------------------------------------------------------
module catmull_rom_route_sampler
    import crrs_pkg::*;
#(
    parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [CFG_W-1:0]   i_cfg_wdata,
    input  logic               i_s_axis_tvalid,
    output logic               o_s_axis_tready,
    input  logic [95:0]        i_s_axis_tdata,   // point_x, point_y, point_z
    input  logic               i_s_axis_tlast,
    output logic               o_m_axis_tvalid,
    input  logic               i_m_axis_tready,
    output logic [111:0]       o_m_axis_tdata,   // sample_x, sample_y, sample_z, heading
    output logic               o_m_axis_tlast
);

    t_cmd                   w_cmd;
    t_stat                  w_stat;
    logic signed [PT_W-1:0] w_sx, w_sy, w_sz;
    logic signed [HW-1:0]   w_hd;

    crrs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    crrs_dp #(
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_pt_x      (i_s_axis_tdata[31:0]),
        .i_pt_y      (i_s_axis_tdata[63:32]),
        .i_pt_z      (i_s_axis_tdata[95:64]),
        .i_pt_fin    (i_s_axis_tlast),
        .o_smp_x     (w_sx),
        .o_smp_y     (w_sy),
        .o_smp_z     (w_sz),
        .o_heading   (w_hd),
        .o_last      (o_m_axis_tlast),
        .o_valid     (o_m_axis_tvalid),
        .i_ready     (i_m_axis_tready)
    );

    assign o_m_axis_tdata = {w_hd, w_sz, w_sy, w_sx};

endmodule

[hdl/crrs_checker.sv]
// ---------------------------------------------------------------------------
// Route sampler checker
// Port-level checks on the sample stream, bound to the top level.
// ---------------------------------------------------------------------------
`include "catmull_rom_route_sampler_macros.svh"

module crrs_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         o_s_axis_tready,
    input logic         o_m_axis_tvalid,
    input logic         i_m_axis_tready,
    input logic [111:0] o_m_axis_tdata,
    input logic         o_m_axis_tlast
);

    `CRRS_ASSERT_NEXT(a_hold_stalled, o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast))

    `CRRS_ASSERT_NOW(a_heading_range, o_m_axis_tvalid, $signed(o_m_axis_tdata[111:96]) <= 16'sd25736 && $signed(o_m_axis_tdata[111:96]) >= -16'sd25736)

    `CRRS_ASSERT_NEXT(a_busy_mid_point, o_m_axis_tvalid && i_m_axis_tready && !o_m_axis_tlast, !o_s_axis_tready)

endmodule

bind catmull_rom_route_sampler crrs_checker u_crrs_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tlast  (o_m_axis_tlast)
);
